@@ rtl/core/sgdm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgdm_pkg: shared definitions for the momentum optimizer block
// Word widths, configuration register indexes, reset values and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdm_pkg;

  localparam int DATA_W = 32;                 // Q16.16 data word
  localparam int COEF_W = 16;                 // unsigned Q0.16 coefficient
  localparam int IDX_W  = 12;                 // element index field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W  = COEF_W + 1 + DATA_W; // signed coef * word product
  localparam int SUM_W  = MUL_W + 1;           // product plus a word, exact

  localparam int ELEMENTS_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE   = 2'd0,
    CFG_MOMENTUM_FACTOR = 2'd1,
    CFG_NESTEROV_MODE   = 2'd2
  } cfg_reg_t;

  localparam logic [COEF_W-1:0] LR_RESET  = 16'd655;
  localparam logic [COEF_W-1:0] MOM_RESET = 16'd0;

  typedef logic signed [DATA_W-1:0] word_t;

  // clamp an exact sum to the signed word range
  function automatic word_t sat_word(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-DATA_W:0] top;
    word_t res;
    top = x[SUM_W-1:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      res = x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sgdm_out_buf.sv @@
// ----------------------------------------------------------------------------
// sgdm_out_buf: two-word output buffer
// Parts the pipeline from the result channel; full is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdm_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sgdm_pkg::word_t      push_data,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sgdm_pkg::word_t           new_param
);

  sgdm_pkg::word_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign new_param = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sgd_momentum_update.sv @@
// ----------------------------------------------------------------------------
// sgd_momentum_update: element-wise SGD step with classic or Nesterov momentum
// Reads the momentum word of an element, updates it, writes it back and
// returns the saturated new parameter value.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | in_valid / in_stall        | element_index, param_value,
//           |                            | grad_value
//  result   | out_valid / out_stall      | new_param
//  config   | cfg_write (no handshake)   | cfg_index, cfg_data
//
//  one word accepted per cycle while in_stall is low; five pipeline stages,
//  the last one feeding the output buffer
//  the momentum recurrence closes in stage 2: one 17x32 multiply, round, add
//  and clamp per advancing cycle, with the stage 2 result forwarded back to stage 1
//  after reset a clearing pass zeroes the momentum memory, with in_stall
//  high throughout
//  the pipeline holds only when the two-word output buffer is full, so
//  input keeps flowing while one result waits
//
`default_nettype none

module sgd_momentum_update #(
  parameter int ELEMENTS  = sgdm_pkg::ELEMENTS_DEF,
  parameter int FRAC_BITS = sgdm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sgdm_pkg::IDX_W-1:0]          element_index,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]  param_value,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]  grad_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [sgdm_pkg::DATA_W-1:0]       new_param,
  // configuration port
  input  wire logic                                cfg_write,
  input  wire logic [sgdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sgdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int DW    = sgdm_pkg::DATA_W;
  localparam int CW    = sgdm_pkg::COEF_W;
  localparam int IW    = sgdm_pkg::IDX_W;
  localparam int MW    = sgdm_pkg::MUL_W;
  localparam int SW    = sgdm_pkg::SUM_W;
  localparam logic signed [MW-1:0] RND_BIAS = {{(MW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENTS - 1);

  // configuration registers
  logic [CW-1:0] learning_rate;
  logic [CW-1:0] momentum_factor;
  logic          nesterov_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= sgdm_pkg::LR_RESET;
      momentum_factor <= sgdm_pkg::MOM_RESET;
      nesterov_mode   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sgdm_pkg::CFG_LEARNING_RATE:   learning_rate   <= cfg_data;
        sgdm_pkg::CFG_MOMENTUM_FACTOR: momentum_factor <= cfg_data;
        sgdm_pkg::CFG_NESTEROV_MODE:   nesterov_mode   <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // clearing pass over the momentum memory after reset
  logic          clearing;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  // pipeline advance: hold only while the output buffer is full
  logic buf_full;
  logic adv;
  logic in_take;

  assign adv      = !buf_full;
  assign in_stall = clearing || buf_full;
  assign in_take  = in_valid && !in_stall;

  // stage 1: captured word and momentum memory read
  logic          v1;
  logic [IW-1:0] idx1;
  logic          inr1;
  sgdm_pkg::word_t p1, g1, rdata;

  logic [DW-1:0] mem [ELEMENTS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  sgdm_pkg::word_t b_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[AW'(element_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= element_index;
      inr1 <= (32'(element_index) < 32'(ELEMENTS));
      p1   <= param_value;
      g1   <= grad_value;
    end
  end

  // stage 2 registers, also the forwarding source
  logic          v2;
  logic [IW-1:0] idx2;
  logic          inr2;
  sgdm_pkg::word_t p2, g2, b2;

  // momentum recurrence: b = sat(rnd(m * b_prev) + g)
  sgdm_pkg::word_t       bprev;
  logic signed [MW-1:0]  prod_a;
  logic signed [MW-1:0]  rnd_a;
  logic signed [SW-1:0]  sum_a;

  always_comb begin
    if (!inr1) begin
      bprev = '0;
    end else if (v2 && inr2 && (idx2 == idx1)) begin
      bprev = b2;  // word ahead wrote this slot at the edge of our read
    end else begin
      bprev = rdata;
    end
    prod_a = $signed({1'b0, momentum_factor}) * bprev;
    rnd_a  = (prod_a + RND_BIAS) >>> FRAC_BITS;
    sum_a  = SW'(rnd_a) + SW'(g1);
    b_a    = sgdm_pkg::sat_word(sum_a);
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && v1 && inr1;
      mem_waddr = AW'(idx1);
      mem_wdata = b_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2 <= idx1;
      inr2 <= inr1;
      p2   <= p1;
      g2   <= g1;
      b2   <= b_a;
    end
  end

  // stage 3: lookahead product m * b
  logic                 v3;
  sgdm_pkg::word_t      p3, g3, b3;
  logic signed [MW-1:0] prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3    <= p2;
      g3    <= g2;
      b3    <= b2;
      prod3 <= $signed({1'b0, momentum_factor}) * b2;
    end
  end

  // stage 4: step gradient, Nesterov or classic
  logic                 v4;
  sgdm_pkg::word_t      p4, gs4, gstep_c;
  logic signed [MW-1:0] rnd_c;

  always_comb begin
    rnd_c = (prod3 + RND_BIAS) >>> FRAC_BITS;
    if (nesterov_mode) begin
      gstep_c = sgdm_pkg::sat_word(SW'(g3) + SW'(rnd_c));
    end else begin
      gstep_c = b3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4  <= p3;
      gs4 <= gstep_c;
    end
  end

  // stage 5: learning rate product
  logic                 v5;
  sgdm_pkg::word_t      p5;
  logic signed [MW-1:0] prod5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5    <= p4;
      prod5 <= $signed({1'b0, learning_rate}) * gs4;
    end
  end

  // final subtract and clamp, into the output buffer
  logic signed [MW-1:0] rnd_e;
  sgdm_pkg::word_t      np_e;

  always_comb begin
    rnd_e = (prod5 + RND_BIAS) >>> FRAC_BITS;
    np_e  = sgdm_pkg::sat_word(SW'(p5) - SW'(rnd_e));
  end

  sgdm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && v5),
    .push_data (np_e),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_param (new_param)
  );

endmodule

`default_nettype wire

@@ rtl/core/sgdm_checker.sv @@
// ----------------------------------------------------------------------------
// sgdm_checker: port-level checks for the momentum optimizer block
// Tracks words in flight and watches reset and result channel behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdm_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [sgdm_pkg::DATA_W-1:0]  new_param
);

  localparam logic [3:0] MAX_IN_FLIGHT = 4'd7;  // five stages plus two buffer words

  logic       in_acc;
  logic       out_acc;
  logic [3:0] in_flight;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 4'd0;
    end else if (in_acc && !out_acc) begin
      in_flight <= in_flight + 4'd1;
    end else if (out_acc && !in_acc) begin
      in_flight <= in_flight - 4'd1;
    end
  end

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(new_param)))
    else $error("result changed while stalled");

  // no result without an accepted word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_flight != 4'd0))
    else $error("result with no word in flight");

  // never more words in flight than the pipeline and buffer hold
  a_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= MAX_IN_FLIGHT)
    else $error("too many words in flight");

  // clearing pass holds off input, and no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> (in_stall && !out_valid))
    else $error("input open or result shown right after reset");

endmodule

bind sgd_momentum_update sgdm_checker u_sgdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .new_param (new_param)
);

`default_nettype wire

@@ tb/sgd_momentum_update_checker.sv @@
// ----------------------------------------------------------------------------
// sgd_momentum_update_checker: result predictor and scoreboard
// Watches the input, result and register ports of the optimizer block. It
// keeps its own momentum memory and register copies, predicts each new
// parameter and compares it with the block's result words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_momentum_update_checker #(
  parameter int ELEMENTS  = sgdm_pkg::ELEMENTS_DEF,
  parameter int FRAC_BITS = sgdm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_stall,
  input  wire logic [sgdm_pkg::IDX_W-1:0]           element_index,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]   param_value,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]   grad_value,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_stall,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]   new_param,
  input  wire logic                                 cfg_write,
  input  wire logic [sgdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sgdm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                        fail_count,
  output int                                        pending
);

  localparam int SHOWN_MAX = 10;

  sgdm_pkg::word_t             momentum_mem [ELEMENTS];
  logic [sgdm_pkg::COEF_W-1:0] lr_q;
  logic [sgdm_pkg::COEF_W-1:0] mom_q;
  logic                        nesterov_q;
  sgdm_pkg::word_t             expected_params [$];

  int fails  = 0;
  int queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  // coefficient times word, rounded half up at the binary point
  function automatic longint round_scale(input logic [sgdm_pkg::COEF_W-1:0] coef,
                                         input sgdm_pkg::word_t v);
    longint prod;
    prod = longint'(coef) * longint'(v) + (64'sd1 <<< (FRAC_BITS - 1));
    return prod >>> FRAC_BITS;
  endfunction

  function automatic sgdm_pkg::word_t clamp_word(input longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return sgdm_pkg::word_t'(x);
  endfunction

  // one optimizer step: new momentum is stored, new parameter returned
  function automatic sgdm_pkg::word_t update_element(input logic [sgdm_pkg::IDX_W-1:0] idx,
                                                     input sgdm_pkg::word_t p,
                                                     input sgdm_pkg::word_t g);
    sgdm_pkg::word_t b_prev;
    sgdm_pkg::word_t b;
    sgdm_pkg::word_t g_step;
    logic            in_range;
    in_range = (int'(idx) < ELEMENTS);
    b_prev   = in_range ? momentum_mem[idx] : '0;
    b        = clamp_word(round_scale(mom_q, b_prev) + longint'(g));
    g_step   = nesterov_q ? clamp_word(longint'(g) + round_scale(mom_q, b)) : b;
    if (in_range) begin
      momentum_mem[idx] = b;
    end
    return clamp_word(longint'(p) - round_scale(lr_q, g_step));
  endfunction

  always @(posedge clk) begin
    sgdm_pkg::word_t want;
    if (rst) begin
      foreach (momentum_mem[i]) momentum_mem[i] = '0;
      lr_q       = sgdm_pkg::LR_RESET;
      mom_q      = sgdm_pkg::MOM_RESET;
      nesterov_q = 1'b0;
      expected_params.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sgdm_pkg::CFG_LEARNING_RATE:   lr_q = cfg_data[sgdm_pkg::COEF_W-1:0];
          sgdm_pkg::CFG_MOMENTUM_FACTOR: mom_q = cfg_data[sgdm_pkg::COEF_W-1:0];
          sgdm_pkg::CFG_NESTEROV_MODE:   nesterov_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_params.size() == 0) begin
          if (fails < SHOWN_MAX) begin
            $display("%0t: unexpected result word new_param=0x%08h", $time, new_param);
          end
          fails++;
        end else begin
          want = expected_params.pop_front();
          if (new_param !== want) begin
            if (fails < SHOWN_MAX) begin
              $display("%0t: new_param mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                       $time, want, want, new_param, new_param);
            end
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_params.push_back(update_element(element_index, param_value, grad_value));
      end
    end
    queued = expected_params.size();
  end

endmodule

`default_nettype wire

@@ tb/sgd_momentum_update_tb.sv @@
// ----------------------------------------------------------------------------
// sgd_momentum_update_tb: stimulus and verdict for the momentum optimizer
// Drives directed corner words and then random words over several register
// settings and idle profiles; a checker beside the block scores each result.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_momentum_update_tb;

  localparam int     CLK_HALF        = 5;
  localparam int     RESET_CYCLES    = 10;
  localparam int     HOT_SLOTS       = 16;
  localparam int     HOT_W           = $clog2(HOT_SLOTS);
  localparam int     SEGMENTS        = 6;
  localparam int     WORDS_PER_SEG   = 122;
  localparam int     TAIL_CYCLES     = 20;
  localparam longint RUN_LIMIT       = 3000000;
  // index past the last register, the block must ignore writes to it
  localparam logic [sgdm_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam sgdm_pkg::word_t WORD_MAX = 32'sh7fff_ffff;
  localparam sgdm_pkg::word_t WORD_MIN = 32'sh8000_0000;
  localparam sgdm_pkg::word_t WORD_ONE = 32'sh0001_0000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [sgdm_pkg::IDX_W-1:0]      element_index = '0;
  sgdm_pkg::word_t                 param_value = '0;
  sgdm_pkg::word_t                 grad_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  sgdm_pkg::word_t                 new_param;
  logic                            cfg_write = 1'b0;
  logic [sgdm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sgdm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_results;

  // idle percentages for the sender and the receiver
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // a few slots that are hit again and again so momentum builds up
  logic [sgdm_pkg::IDX_W-1:0] hot_slots [HOT_SLOTS];

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  sgd_momentum_update DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_index (element_index),
    .param_value   (param_value),
    .grad_value    (grad_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_param     (new_param),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sgd_momentum_update_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_index (element_index),
    .param_value   (param_value),
    .grad_value    (grad_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_param     (new_param),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending_results)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
  end

  // hard stop in case the handshakes hang
  initial begin
    #(RUN_LIMIT);
    $display("** sgd_momentum_update: FAILED **");
    $finish;
  end

  // one input word; called and returns at a falling edge, valid left high
  task automatic send_word(input logic [sgdm_pkg::IDX_W-1:0] idx, input sgdm_pkg::word_t p,
                           input sgdm_pkg::word_t g);
    while ((tx_idle_pct > 0) && ($urandom_range(99) < tx_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    element_index <= idx;
    param_value   <= p;
    grad_value    <= g;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write enable stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [sgdm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sgdm_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [sgdm_pkg::COEF_W-1:0] lr,
                              input logic [sgdm_pkg::COEF_W-1:0] mom,
                              input logic [sgdm_pkg::CFG_DATA_W-1:0] nest);
    drain_results();
    write_reg(sgdm_pkg::CFG_LEARNING_RATE, lr);
    write_reg(sgdm_pkg::CFG_MOMENTUM_FACTOR, mom);
    write_reg(sgdm_pkg::CFG_NESTEROV_MODE, nest);
    // junk write to the unused index must leave everything alone
    write_reg(CFG_SPARE_INDEX, sgdm_pkg::CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // operand mix: extremes, tiny values for rounding, typical Q16.16, raw bits
  function automatic sgdm_pkg::word_t next_operand();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return sgdm_pkg::word_t'(int'($urandom_range(0, 511)) - 256);
      4, 5:    return sgdm_pkg::word_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return sgdm_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic logic [sgdm_pkg::IDX_W-1:0] next_index();
    if ($urandom_range(3) != 0) begin
      return hot_slots[HOT_W'($urandom_range(HOT_SLOTS - 1))];
    end
    return sgdm_pkg::IDX_W'($urandom);
  endfunction

  initial begin
    hot_slots[0] = '0;
    hot_slots[1] = '1;
    for (int i = 2; i < HOT_SLOTS; i++) hot_slots[i] = sgdm_pkg::IDX_W'($urandom);

    tx_idle_pct = 11;
    rx_idle_pct = 64;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset settings: small step, no momentum, classic mode
    send_word('0, '0, '0);
    send_word('1, WORD_MAX, WORD_MIN);
    send_word(12'd1, WORD_MIN, WORD_MAX);
    send_word(12'd2, WORD_MAX, WORD_MAX);
    send_word(12'd3, WORD_MIN, WORD_MIN);
    send_word('0, WORD_ONE, WORD_ONE);
    send_word('1, '0, -32'sd1);

    // full step and full momentum, nesterov: momentum runs into saturation
    program_regs(16'hffff, 16'hffff, 16'd1);
    send_word(12'd5, '0, WORD_MAX);
    send_word(12'd5, '0, WORD_MAX);
    send_word(12'd5, WORD_MIN, WORD_MAX);
    send_word(12'd5, WORD_MAX, WORD_MIN);
    send_word(12'd5, '0, WORD_MIN);
    send_word('1, WORD_ONE, -WORD_ONE);

    // classic mode, same momentum: reuses the slot built up above
    program_regs(16'hffff, 16'hffff, 16'd0);
    send_word(12'd5, '0, '0);
    send_word('1, '0, WORD_ONE);

    // zero momentum with a half step: plain sgd and rounding at the half
    program_regs(16'h8000, 16'h0000, 16'h0000);
    send_word(12'd7, '0, 32'sd1);
    send_word(12'd7, '0, -32'sd1);
    send_word(12'd7, '0, 32'sd3);
    send_word(12'd7, '0, -32'sd3);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // first sender-light / receiver-heavy, then reversed, then no idling
      if (seg < 2) begin
        tx_idle_pct = 11;
        rx_idle_pct = 64;
      end else if (seg < 4) begin
        tx_idle_pct = 64;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg)
        0: program_regs(16'hffff, 16'hffff, 16'd1);
        // nesterov field only takes bit zero
        1: program_regs(16'h0000, 16'h0000, 16'hfffe);
        2: program_regs(sgdm_pkg::COEF_W'($urandom), sgdm_pkg::COEF_W'($urandom), 16'h8001);
        3: program_regs(16'd655, 16'h8000, 16'd0);
        4: program_regs(16'd1, 16'hffff, 16'd0);
        default: program_regs(sgdm_pkg::COEF_W'($urandom), sgdm_pkg::COEF_W'($urandom),
                              sgdm_pkg::CFG_DATA_W'($urandom));
      endcase
      for (int n = 0; n < WORDS_PER_SEG; n++) begin
        send_word(next_index(), next_operand(), next_operand());
      end
    end

    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    // give stray words time to come out of the pipeline and buffer
    repeat (TAIL_CYCLES) @(negedge clk);
    if ((fail_count == 0) && (pending_results == 0)) begin
      $display("** sgd_momentum_update: PASSED **");
    end else begin
      $display("** sgd_momentum_update: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sgd_momentum_update.f @@
rtl/core/sgdm_pkg.sv
rtl/core/sgdm_out_buf.sv
rtl/core/sgd_momentum_update.sv
rtl/core/sgdm_checker.sv
tb/sgd_momentum_update_checker.sv
tb/sgd_momentum_update_tb.sv
